[rtl/asi32_pkg.sv]
// ----------------------------------------------------------------------------
// asi32_pkg
// shared types and constants for the audio sample to int32 converter
// ----------------------------------------------------------------------------
package asi32_pkg;

  // sample format codes, code 7 is unused and converts to zero
  typedef enum logic [2:0] {
    FMT_U8    = 3'd0,
    FMT_S16   = 3'd1,
    FMT_S24   = 3'd2,
    FMT_S32   = 3'd3,
    FMT_F32   = 3'd4,
    FMT_ALAW  = 3'd5,
    FMT_MULAW = 3'd6
  } sample_format_t;

  localparam sample_format_t FMT_RESET = FMT_S16;

  localparam logic [31:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_MIN = 32'h8000_0000;

  // g711 companding law select
  typedef enum logic {
    LAW_A  = 1'b0,
    LAW_MU = 1'b1
  } g711_law_t;

endpackage

[rtl/asi32_g711_expand.sv]
// ----------------------------------------------------------------------------
// asi32_g711_expand
// g.711 a-law or mu-law byte to signed 16-bit linear
// ----------------------------------------------------------------------------
module asi32_g711_expand (
  input  logic [7:0]        code,
  input  asi32_pkg::g711_law_t law,
  output logic [15:0]       linear
);

  logic [7:0]  a;
  logic [2:0]  a_seg;
  logic [15:0] a_mag;
  logic [15:0] a_lin;
  logic [7:0]  u;
  logic [15:0] u_t;
  logic [15:0] u_lin;

  // a-law
  always_comb begin
    a     = code ^ 8'h55;
    a_seg = a[6:4];
    if (a_seg == 3'd0) begin
      a_mag = {8'd0, a[3:0], 4'd0} + 16'd8;
    end else begin
      a_mag = ({8'd0, a[3:0], 4'd0} + 16'h0108) << (a_seg - 3'd1);
    end
    a_lin = a[7] ? a_mag : (16'd0 - a_mag);
  end

  // mu-law
  always_comb begin
    u     = ~code;
    u_t   = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
    u_lin = u[7] ? (16'h0084 - u_t) : (u_t - 16'h0084);
  end

  assign linear = (law == asi32_pkg::LAW_MU) ? u_lin : a_lin;

endmodule

[rtl/asi32_float_q31.sv]
// ----------------------------------------------------------------------------
// asi32_float_q31
// ieee binary32 to q1.31 with exact round-half-away and saturation
// ----------------------------------------------------------------------------
module asi32_float_q31 (
  input  logic [31:0] bits,
  output logic [31:0] q31
);

  logic        neg;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic [23:0] m;
  logic [54:0] prod;
  logic [7:0]  sh;
  logic [55:0] rnd;
  logic [55:0] sum;
  logic [55:0] shifted;
  logic [31:0] mag;
  logic [31:0] sat;

  always_comb begin
    neg  = bits[31];
    ex   = bits[30:23];
    frac = bits[22:0];
    m    = {1'b1, frac};
    // positive scale is 2^31-1, negative scale is 2^31
    if (neg) begin
      prod = {m, 31'd0};
    end else begin
      prod = {m, 31'd0} - {31'd0, m};
    end
    // shift lies in 24..149 for normal values below one
    sh      = 8'd150 - ex;
    rnd     = 56'd1 << (sh[5:0] - 6'd1);
    sum     = {1'b0, prod} + rnd;
    shifted = sum >> sh[5:0];
    mag     = shifted[31:0];
    sat     = neg ? asi32_pkg::Q31_MIN : asi32_pkg::Q31_MAX;

    if (ex == 8'hFF) begin
      q31 = (frac != 23'd0) ? 32'd0 : sat;
    end else if (ex == 8'd0) begin
      q31 = 32'd0;
    end else if (ex >= 8'd127) begin
      q31 = sat;
    end else if (sh > 8'd55) begin
      // too small to reach the rounding point
      q31 = 32'd0;
    end else begin
      q31 = neg ? (32'd0 - mag) : mag;
    end
  end

endmodule

[rtl/audio_sample_to_int32_converter.sv]
// ----------------------------------------------------------------------------
// audio_sample_to_int32_converter
// stored audio sample to signed 32-bit linear sample
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_stall is low and returns it as a
// signed q1.31 value (int24 is only sign-extended, not left-justified),
// with the last flag copied alongside. Sample bytes are little-endian in
// raw_sample. sample_format (reset int16) picks uint8, int16, int24, int32,
// float32, a-law or mu-law; code 7 gives zero. Throughput is one transfer
// per cycle while out_stall is low, set by the two-register pipeline: an
// input register, then the conversion logic, then the result register.
// cfg_ready is always high; write the format only while no sample is in flight.
module audio_sample_to_int32_converter (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] raw_sample,
  input  logic        last_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] linear_sample,
  output logic        last_out,
  // format register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  asi32_pkg::sample_format_t sample_format;

  // input register
  logic        s1_valid;
  logic [31:0] s1_raw;
  logic        s1_last;

  // handshake
  logic out_ready;
  logic s1_load;
  logic s1_move;

  // conversion
  logic [15:0] g711_linear;
  logic [31:0] float_q31;
  logic [31:0] result_next;
  asi32_pkg::g711_law_t law;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= asi32_pkg::FMT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sample_format <= asi32_pkg::sample_format_t'(cfg_data);
    end
  end

  // result register frees up when empty or taken this cycle
  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign s1_load   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_raw  <= raw_sample;
      s1_last <= last_in;
    end
  end

  assign law = (sample_format == asi32_pkg::FMT_MULAW) ? asi32_pkg::LAW_MU
                                                       : asi32_pkg::LAW_A;

  asi32_g711_expand u_g711 (
    .code   (s1_raw[7:0]),
    .law    (law),
    .linear (g711_linear)
  );

  asi32_float_q31 u_float (
    .bits (s1_raw),
    .q31  (float_q31)
  );

  // format select
  always_comb begin
    case (sample_format)
      asi32_pkg::FMT_U8:    result_next = {s1_raw[7] ^ 1'b1, s1_raw[6:0], 24'd0};
      asi32_pkg::FMT_S16:   result_next = {s1_raw[15:0], 16'd0};
      asi32_pkg::FMT_S24:   result_next = {{8{s1_raw[23]}}, s1_raw[23:0]};
      asi32_pkg::FMT_S32:   result_next = s1_raw;
      asi32_pkg::FMT_F32:   result_next = float_q31;
      asi32_pkg::FMT_ALAW:  result_next = {g711_linear, 16'd0};
      asi32_pkg::FMT_MULAW: result_next = {g711_linear, 16'd0};
      default:              result_next = 32'd0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      linear_sample <= result_next;
      last_out      <= s1_last;
    end
  end

  // an accepted sample lands in the input register
  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> s1_valid)
    else $error("accepted sample did not reach input register");

  // a sample that moves on shows up as a result
  a_move_shows: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("converted sample lost before result register");

  // a blocked input register keeps its sample
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_ready) |=> (s1_valid && $stable(s1_raw) && $stable(s1_last)))
    else $error("blocked input register changed");

  // a format write takes effect on the next cycle
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (sample_format == $past(cfg_data)))
    else $error("format write not taken");

endmodule
